[rtl/core/rdwr_pkg.sv]
// Shared constants for the card pool draw block and its port checker.
`default_nettype none

package rdwr_pkg;

    // Input word layout: random value in the low bits of tdata
    localparam int RND_W      = 31;
    localparam int S_DATA_W   = 32;
    localparam int STEP_W     = $clog2(RND_W + 1);

    // Output word layout: suit, then rank, padded to one byte
    localparam int SUIT_OUT_W = 2;
    localparam int RANK_OUT_W = 4;
    localparam int M_DATA_W   = 8;

    // Request kinds carried on s_tuser
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_DRAW    = 1'b1;

endpackage

`default_nettype wire

[rtl/core/random_draw_without_replacement.sv]
// Card pool with uniform draw without replacement, pool held in one synchronous RAM.
// Draw: from accept to result word the block runs 31 modulo steps, a read, a capture, a shift
// down of each later entry, then the output; an empty pool goes straight to the output.
// Restart: no result; refills the RAM at one entry a cycle, all SUITS*RANKS entries.
// One item in flight; the next word is taken the cycle after the result is queued on m_*.
// Reset (aresetn low, synchronous): same refill sweep, s_tready low until it ends.
`default_nettype none

module random_draw_without_replacement #(
    parameter int SUITS = 4,
    parameter int RANKS = 13
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rdwr_pkg::S_DATA_W-1:0] s_tdata,   // [30:0] random_value
    input  wire logic                          s_tuser,   // [0] req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rdwr_pkg::M_DATA_W-1:0]      m_tdata,   // [1:0] suit, [5:2] rank
    output logic                               m_tlast,   // last_card
    output logic                               m_tuser    // [0] empty_error
);
    import rdwr_pkg::*;

    localparam int DECK      = SUITS * RANKS;
    localparam int HALF      = DECK / 2;
    localparam int ODD_DECK  = DECK % 2;
    localparam int ADDR_W    = $clog2(DECK);
    localparam int CNT_W     = $clog2(DECK + 1);
    localparam int CW1       = CNT_W + 1;
    localparam int SUIT_W    = (SUITS > 1) ? $clog2(SUITS) : 1;
    localparam int RANK_W    = $clog2(RANKS);
    localparam int ENTRY_W   = SUIT_W + RANK_W;
    localparam int B0_SUIT   = HALF / RANKS;
    localparam int B0_RANK   = HALF % RANKS;

    localparam logic [2:0] ST_FILL  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_CAP   = 3'd4;
    localparam logic [2:0] ST_SHIFT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // pool RAM: each entry holds {suit, rank}
    logic [ENTRY_W-1:0] pool_mem [DECK];
    logic [ENTRY_W-1:0] rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  fill_addr_reg, fill_addr_next;
    logic [SUIT_W-1:0]  a_suit_reg, a_suit_next, b_suit_reg, b_suit_next;
    logic [RANK_W-1:0]  a_rank_reg, a_rank_next, b_rank_reg, b_rank_next;
    logic [CNT_W-1:0]   remaining_reg, remaining_next;
    logic [RND_W-1:0]   dividend_reg, dividend_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [ENTRY_W-1:0] card_reg, card_next;
    logic               err_reg, err_next;
    logic               m_valid_reg, m_valid_next;
    logic [SUIT_OUT_W-1:0] m_suit_reg, m_suit_next;
    logic [RANK_OUT_W-1:0] m_rank_reg, m_rank_next;
    logic               m_last_reg, m_last_next;
    logic               m_err_reg, m_err_next;

    logic [CW1-1:0]     shifted;
    logic [CW1-1:0]     rem_inc;
    logic [CW1-1:0]     j_inc2;
    logic [SUIT_W+SUIT_OUT_W-1:0] suit_wide;
    logic [RANK_W+RANK_OUT_W-1:0] rank_wide;
    logic               s_fire;
    logic               out_free;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pool_mem[wr_addr] <= wr_data;
        end
        rd_data <= pool_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign shifted   = {rem_reg, dividend_reg[RND_W-1]};
    assign rem_inc   = CW1'(rem_reg) + CW1'(1);
    assign j_inc2    = CW1'(j_reg) + CW1'(2);
    assign suit_wide = {{SUIT_OUT_W{1'b0}}, card_reg[ENTRY_W-1:RANK_W]};
    assign rank_wide = {{RANK_OUT_W{1'b0}}, card_reg[RANK_W-1:0]};

    always_comb begin
        state_next     = state_reg;
        fill_addr_next = fill_addr_reg;
        a_suit_next    = a_suit_reg;
        a_rank_next    = a_rank_reg;
        b_suit_next    = b_suit_reg;
        b_rank_next    = b_rank_reg;
        remaining_next = remaining_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        j_next         = j_reg;
        card_next      = card_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_suit_next    = m_suit_reg;
        m_rank_next    = m_rank_reg;
        m_last_next    = m_last_reg;
        m_err_next     = m_err_reg;
        rd_addr        = '0;
        wr_addr        = fill_addr_reg;
        wr_data        = {a_suit_reg, a_rank_reg};
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_FILL: begin
                wr_en = 1'b1;
                // even slots take the first half, odd slots the second half
                if (ODD_DECK != 0 && fill_addr_reg == ADDR_W'(DECK - 1)) begin
                    wr_data = {SUIT_W'(SUITS - 1), RANK_W'(RANKS - 1)};
                end else if (!fill_addr_reg[0]) begin
                    wr_data = {a_suit_reg, a_rank_reg};
                    if (a_rank_reg == RANK_W'(RANKS - 1)) begin
                        a_rank_next = '0;
                        a_suit_next = a_suit_reg + SUIT_W'(1);
                    end else begin
                        a_rank_next = a_rank_reg + RANK_W'(1);
                    end
                end else begin
                    wr_data = {b_suit_reg, b_rank_reg};
                    if (b_rank_reg == RANK_W'(RANKS - 1)) begin
                        b_rank_next = '0;
                        b_suit_next = b_suit_reg + SUIT_W'(1);
                    end else begin
                        b_rank_next = b_rank_reg + RANK_W'(1);
                    end
                end
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == ADDR_W'(DECK - 1)) begin
                    remaining_next = CNT_W'(DECK);
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == REQ_RESTART) begin
                        fill_addr_next = '0;
                        a_suit_next    = '0;
                        a_rank_next    = '0;
                        b_suit_next    = SUIT_W'(B0_SUIT);
                        b_rank_next    = RANK_W'(B0_RANK);
                        state_next     = ST_FILL;
                    end else if (remaining_reg == '0) begin
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        err_next      = 1'b0;
                        dividend_next = s_tdata[RND_W-1:0];
                        rem_next      = '0;
                        step_next     = STEP_W'(RND_W);
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // one restoring step per cycle, dividend MSB first
                if (shifted >= CW1'(remaining_reg)) begin
                    rem_next = CNT_W'(shifted - CW1'(remaining_reg));
                end else begin
                    rem_next = CNT_W'(shifted);
                end
                dividend_next = {dividend_reg[RND_W-2:0], 1'b0};
                step_next     = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                rd_addr    = rem_reg[ADDR_W-1:0];
                state_next = ST_CAP;
            end
            ST_CAP: begin
                card_next = rd_data;
                j_next    = rem_reg[ADDR_W-1:0];
                if (rem_inc < CW1'(remaining_reg)) begin
                    rd_addr    = rem_inc[ADDR_W-1:0];
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT: begin
                // write entry j from j+1 while fetching j+2 ahead
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_data;
                j_next  = j_reg + ADDR_W'(1);
                if (j_inc2 < CW1'(remaining_reg)) begin
                    rd_addr = j_inc2[ADDR_W-1:0];
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    if (err_reg) begin
                        m_suit_next = '0;
                        m_rank_next = '0;
                        m_last_next = 1'b0;
                    end else begin
                        m_suit_next    = suit_wide[SUIT_OUT_W-1:0];
                        m_rank_next    = rank_wide[RANK_OUT_W-1:0];
                        m_last_next    = (remaining_reg == CNT_W'(1));
                        remaining_next = remaining_reg - CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
            a_suit_reg    <= '0;
            a_rank_reg    <= '0;
            b_suit_reg    <= SUIT_W'(B0_SUIT);
            b_rank_reg    <= RANK_W'(B0_RANK);
            remaining_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            a_suit_reg    <= a_suit_next;
            a_rank_reg    <= a_rank_next;
            b_suit_reg    <= b_suit_next;
            b_rank_reg    <= b_rank_next;
            remaining_reg <= remaining_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        j_reg        <= j_next;
        card_reg     <= card_next;
        err_reg      <= err_next;
        m_suit_reg   <= m_suit_next;
        m_rank_reg   <= m_rank_next;
        m_last_reg   <= m_last_next;
        m_err_reg    <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SUIT_OUT_W - RANK_OUT_W){1'b0}}, m_rank_reg, m_suit_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

endmodule

`default_nettype wire

[rtl/core/rdwr_checker.sv]
// Port-level checks for the card pool draw block, bound to its top level.
`default_nettype none

module rdwr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rdwr_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);
    import rdwr_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result word changed");

    // an empty-pool word carries no card and never marks the last card
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("empty error word carries card data");

    // padding above the rank stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:SUIT_OUT_W+RANK_OUT_W] == '0)
        else $error("result padding not zero");

    // one word in flight: drop ready right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // refill sweep after reset keeps the input closed
    a_reset_fill: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid right after reset");

endmodule

bind random_draw_without_replacement rdwr_checker u_rdwr_checker (.*);

`default_nettype wire

[tb/random_draw_without_replacement_tb.sv]
// Self-checking testbench for the card pool draw block: stream stimulus, scoreboard, pass/fail.
`timescale 1ns / 1ps

module random_draw_without_replacement_tb;

    import rdwr_pkg::*;

    localparam int SUITS       = 4;
    localparam int RANKS       = 13;
    localparam int CLK_HALF    = 5;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_PCT    = 23;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [RND_W-1:0] RND_MAX = '1;

    typedef struct packed {
        logic [SUIT_OUT_W-1:0] suit;
        logic [RANK_OUT_W-1:0] rank;
        logic                  last_card;
        logic                  empty_error;
    } draw_result_t;

    // Tracks the pool contents and the draws still owed by the block.
    class card_pool_scoreboard;
        int unsigned  suits;
        int unsigned  ranks;
        int unsigned  pool[$];
        draw_result_t expected_draws[$];
        int           errors;

        function new(int unsigned n_suits, int unsigned n_ranks);
            suits  = n_suits;
            ranks  = n_ranks;
            errors = 0;
            refill();
        endfunction

        // Interleave the two halves of the ordered deck; an odd card goes last.
        function void refill();
            int unsigned deck;
            int unsigned half;
            deck = suits * ranks;
            half = deck / 2;
            pool.delete();
            for (int unsigned i = 0; i < half; i++) begin
                pool.push_back(i);
                pool.push_back(i + half);
            end
            if (deck % 2 != 0)
                pool.push_back(deck - 1);
        endfunction

        function void note_input(logic req, logic [RND_W-1:0] rnd);
            draw_result_t exp_draw;
            int unsigned  idx;
            int unsigned  code;
            if (req == REQ_RESTART) begin
                refill();
                return;
            end
            exp_draw = '0;
            if (pool.size() == 0) begin
                exp_draw.empty_error = 1'b1;
            end else begin
                idx  = rnd % pool.size();
                code = pool[idx];
                pool.delete(idx);
                exp_draw.suit      = SUIT_OUT_W'((code / ranks) & 32'h3);
                exp_draw.rank      = RANK_OUT_W'((code % ranks) & 32'hF);
                exp_draw.last_card = (pool.size() == 0);
            end
            expected_draws.push_back(exp_draw);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic last, logic err);
            draw_result_t exp_draw;
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected result word, expected none",
                         $time);
                $display("    actual data=%0h last=%0b err=%0b", data, last, err);
                errors++;
                return;
            end
            exp_draw = expected_draws.pop_front();
            compare_field("suit", 32'(exp_draw.suit), 32'(data[SUIT_OUT_W-1:0]));
            compare_field("rank", 32'(exp_draw.rank), 32'(data[SUIT_OUT_W +: RANK_OUT_W]));
            compare_field("last_card", 32'(exp_draw.last_card), 32'(last));
            compare_field("empty_error", 32'(exp_draw.empty_error), 32'(err));
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    card_pool_scoreboard draws_sb = new(SUITS, RANKS);
    int                  sent_words = 0;

    random_draw_without_replacement #(
        .SUITS(SUITS),
        .RANKS(RANKS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            draws_sb.note_input(s_tuser, s_tdata[RND_W-1:0]);
        if (aresetn && m_tvalid && m_tready)
            draws_sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Hold off once for a long stretch, then run a gap-free stretch.
    initial begin : result_sink
        int cycle_count;
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= 3000 && cycle_count < 3400)
                m_tready <= 1'b0;
            else if (cycle_count >= 20000 && cycle_count < 30000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("random_draw_without_replacement_tb: errors");
        $finish;
    end

    function automatic logic [RND_W-1:0] pick_random_value();
        case ($urandom_range(3))
            0, 1:    return RND_W'($urandom);
            2:       return RND_W'($urandom_range(63));
            default: return $urandom_range(1) ? RND_MAX : '0;
        endcase
    endfunction

    task automatic send_word(input logic req, input logic [RND_W-1:0] rnd);
        // Drain everything once mid-run before offering the next word.
        if (sent_words == 700) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (draws_sb.pending() != 0)
                @(posedge aclk);
        end
        if (!(sent_words >= 300 && sent_words < 500)) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - RND_W){1'b0}}, rnd};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_words++;
    endtask

    initial begin : stimulus
        int draw_count;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of the random value, bit patterns, restarts.
        send_word(REQ_DRAW, '0);
        send_word(REQ_DRAW, RND_MAX);
        send_word(REQ_DRAW, 31'h5555_5555);
        send_word(REQ_DRAW, 31'h2AAA_AAAA);
        send_word(REQ_DRAW, 31'd47);
        send_word(REQ_DRAW, 31'd47);
        send_word(REQ_RESTART, RND_MAX);
        send_word(REQ_DRAW, 31'd51);
        send_word(REQ_DRAW, 31'd0);
        send_word(REQ_DRAW, 31'd50);
        send_word(REQ_RESTART, '0);
        send_word(REQ_RESTART, 31'h1234_5678);
        send_word(REQ_DRAW, 31'd52);
        send_word(REQ_DRAW, 31'd51);
        send_word(REQ_DRAW, RND_MAX - 31'd1);
        send_word(REQ_DRAW, 31'h4000_0000);
        send_word(REQ_DRAW, 31'd1);
        send_word(REQ_RESTART, 31'd7);
        send_word(REQ_DRAW, 31'd26);
        send_word(REQ_DRAW, 31'd25);

        // Random: mostly restart-then-draw runs, some running the pool dry.
        while (sent_words < RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                send_word(1'($urandom_range(1)), pick_random_value());
            end else begin
                send_word(REQ_RESTART, pick_random_value());
                if ($urandom_range(2) == 0)
                    draw_count = $urandom_range(SUITS * RANKS + 4, SUITS * RANKS);
                else
                    draw_count = $urandom_range(SUITS * RANKS - 1, 1);
                repeat (draw_count)
                    send_word(REQ_DRAW, pick_random_value());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (draws_sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (draws_sb.errors == 0)
            $display("random_draw_without_replacement_tb: clean");
        else
            $display("random_draw_without_replacement_tb: errors");
        $finish;
    end

endmodule

[random_draw_without_replacement.f]
rtl/core/rdwr_pkg.sv
rtl/core/random_draw_without_replacement.sv
rtl/core/rdwr_checker.sv
tb/random_draw_without_replacement_tb.sv
